// ----- hw/rtl/md5_pkg.sv -----
// Shared constants and functions for the MD5 digest core.
// Used by the front (byte packer) and back (compression) modules.
package md5_pkg;

   localparam int unsigned QueueDepth = 2;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hefcdab89;
   localparam logic [31:0] INIT_C = 32'h98badcfe;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [5:0] LEN_OFFSET  = 6'd56;

   // One block handed from the front to the back.
   typedef struct packed {
      logic [511:0] data;
      logic         final_blk;
   } block_type;

   function automatic logic [31:0] round_const(input logic [5:0] i);
      logic [31:0] k;
      unique case (i)
         6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
         6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
         6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
         6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
         6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
         6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
         6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
         6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
         6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
         6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
         6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
         6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
         6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
         6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
         6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
         6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
         6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
         6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
         6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
         6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
         6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
         default: k = 32'heb86d391;
      endcase
      return k;
   endfunction

   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] r;
      unique case ({i[5:4], i[1:0]})
         4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
         4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
         4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
         4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
      endcase
      return r;
   endfunction

   // Message word index used by round i.
   function automatic logic [3:0] msg_index(input logic [5:0] i);
      logic [3:0] g;
      unique case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(5 * i[3:0] + 1);
         2'd2: g = 4'(3 * i[3:0] + 5);
         default: g = 4'(7 * i[3:0]);
      endcase
      return g;
   endfunction

endpackage

// ----- hw/rtl/md5_front.sv -----
// Front end of the MD5 core: packs bytes into 64-byte blocks and pads.
// Depends on md5_pkg.
module md5_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           data_byte,
   input  logic                 byte_valid,
   input  logic                 last_byte,
   output logic                 blk_valid,
   input  logic                 blk_ready,
   output md5_pkg::block_type   blk_out
);

   typedef enum logic [1:0] {S_BYTES, S_PAD, S_LEN} state_type;

   state_type     state_ff;
   logic [511:0]  buf_ff, buf_in;
   logic [5:0]    fill_ff;
   logic [63:0]   len_ff;
   logic [2:0]    len_idx_ff;
   logic          out_valid_ff;
   md5_pkg::block_type out_ff;
   logic          pad_marker_ff;

   // The front can place a byte when its output slot is free.
   logic          slot_free;
   logic          put;
   logic [7:0]    put_byte;
   logic          put_final;

   assign slot_free = !out_valid_ff || blk_ready;
   assign in_ready  = (state_ff == S_BYTES) && slot_free;
   assign blk_valid = out_valid_ff;
   assign blk_out   = out_ff;

   always_comb begin
      put       = 1'b0;
      put_byte  = md5_pkg::PAD_BYTE;
      put_final = 1'b0;
      unique case (state_ff)
         S_BYTES: begin
            put      = in_valid && slot_free && (byte_valid || last_byte);
            put_byte = byte_valid ? data_byte : md5_pkg::PAD_BYTE;
         end
         S_PAD: begin
            put      = slot_free;
            put_byte = pad_marker_ff ? md5_pkg::PAD_BYTE : 8'h00;
         end
         default: begin
            put       = slot_free;
            put_byte  = len_ff[8*len_idx_ff +: 8];
            put_final = (len_idx_ff == 3'd7);
         end
      endcase
      // Bytes shift in from the top, so after 64 bytes the first one sits in the low bits.
      buf_in = {put_byte, buf_ff[511:8]};
   end

   always_ff @(posedge clock) begin
      if (put) begin
         buf_ff <= buf_in;
      end
      if (put && fill_ff == 6'd63) begin
         out_ff.data      <= buf_in;
         out_ff.final_blk <= put_final;
      end
      if (reset) begin
         state_ff     <= S_BYTES;
         fill_ff      <= '0;
         len_ff       <= '0;
         len_idx_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= (put && fill_ff == 6'd63) || (out_valid_ff && !blk_ready);
         if (put) begin
            fill_ff <= fill_ff + 6'd1;
         end
         unique case (state_ff)
            S_BYTES: begin
               if (in_valid && slot_free) begin
                  if (byte_valid && !last_byte) begin
                     len_ff <= len_ff + 64'd8;
                  end else if (last_byte) begin
                     // A valid last byte is stored; the 0x80 marker follows next.
                     if (byte_valid) begin
                        len_ff <= len_ff + 64'd8;
                        state_ff <= S_PAD;
                     end else begin
                        state_ff <= (fill_ff + 6'd1 == md5_pkg::LEN_OFFSET) ? S_LEN : S_PAD;
                     end
                  end
               end
            end
            S_PAD: begin
               if (slot_free) begin
                  if (fill_ff + 6'd1 == md5_pkg::LEN_OFFSET) begin
                     state_ff <= S_LEN;
                  end
               end
            end
            default: begin
               if (slot_free) begin
                  len_idx_ff <= len_idx_ff + 3'd1;
                  if (put_final) begin
                     state_ff <= S_BYTES;
                     len_ff   <= '0;
                  end
               end
            end
         endcase
      end
   end

   // A valid last byte needs a second slot for 0x80; handled in S_PAD by
   // writing the marker first.
   always_ff @(posedge clock) begin
      if (reset) begin
         pad_marker_ff <= 1'b0;
      end else if (state_ff == S_BYTES && in_valid && slot_free && last_byte && byte_valid) begin
         pad_marker_ff <= 1'b1;
      end else if (state_ff == S_PAD && slot_free) begin
         pad_marker_ff <= 1'b0;
      end
   end

endmodule

// ----- hw/rtl/md5_queue.sv -----
// Short block queue between the MD5 front and back.
// Depends on md5_pkg.
module md5_queue #(
   parameter int unsigned DEPTH = md5_pkg::QueueDepth
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  md5_pkg::block_type wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output md5_pkg::block_type rd_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   md5_pkg::block_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          wr, rd;

   assign wr_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) begin
            wp_ff <= (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         end
         if (rd) begin
            rp_ff <= (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
         end
         cnt_ff <= cnt_ff + (AW+1)'(wr) - (AW+1)'(rd);
      end
   end

endmodule

// ----- hw/rtl/md5_back.sv -----
// Back end of the MD5 core: one compression round per cycle and digest output.
// Depends on md5_pkg.
module md5_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               blk_valid,
   output logic               blk_ready,
   input  md5_pkg::block_type blk_in,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [31:0]        out_word,
   output logic [1:0]         out_index,
   output logic               out_last
);

   typedef enum logic [1:0] {S_IDLE, S_ROUND, S_FOLD, S_EMIT} state_type;

   state_type    state_ff;
   logic [511:0] msg_ff;
   logic         final_ff;
   logic [5:0]   rnd_ff;
   logic [1:0]   emit_ff;
   logic [31:0]  ha_ff, hb_ff, hc_ff, hd_ff;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff;
   logic [31:0]  f, sum, rot, m;
   logic [4:0]   sh;

   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      m   = msg_ff[32*md5_pkg::msg_index(rnd_ff) +: 32];
      sum = a_ff + f + md5_pkg::round_const(rnd_ff) + m;
      sh  = md5_pkg::rot_amount(rnd_ff);
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   end

   assign blk_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_EMIT);
   assign out_index = emit_ff;
   assign out_last  = (emit_ff == 2'd3);
   always_comb begin
      unique case (emit_ff)
         2'd0: out_word = ha_ff;
         2'd1: out_word = hb_ff;
         2'd2: out_word = hc_ff;
         default: out_word = hd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && blk_valid) begin
         msg_ff   <= blk_in.data;
         final_ff <= blk_in.final_blk;
         a_ff <= ha_ff; b_ff <= hb_ff; c_ff <= hc_ff; d_ff <= hd_ff;
      end else if (state_ff == S_ROUND) begin
         a_ff <= d_ff;
         b_ff <= b_ff + rot;
         c_ff <= b_ff;
         d_ff <= c_ff;
      end
      if (reset) begin
         state_ff <= S_IDLE;
         rnd_ff   <= '0;
         emit_ff  <= '0;
         ha_ff <= md5_pkg::INIT_A; hb_ff <= md5_pkg::INIT_B;
         hc_ff <= md5_pkg::INIT_C; hd_ff <= md5_pkg::INIT_D;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (blk_valid) begin
                  state_ff <= S_ROUND;
                  rnd_ff   <= '0;
               end
            end
            S_ROUND: begin
               rnd_ff <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) begin
                  state_ff <= S_FOLD;
               end
            end
            S_FOLD: begin
               ha_ff <= ha_ff + a_ff; hb_ff <= hb_ff + b_ff;
               hc_ff <= hc_ff + c_ff; hd_ff <= hd_ff + d_ff;
               state_ff <= final_ff ? S_EMIT : S_IDLE;
               emit_ff  <= '0;
            end
            default: begin
               if (out_ready) begin
                  emit_ff <= emit_ff + 2'd1;
                  if (emit_ff == 2'd3) begin
                     state_ff <= S_IDLE;
                     ha_ff <= md5_pkg::INIT_A; hb_ff <= md5_pkg::INIT_B;
                     hc_ff <= md5_pkg::INIT_C; hd_ff <= md5_pkg::INIT_D;
                  end
               end
            end
         endcase
      end
   end

endmodule

// ----- hw/rtl/md5_message_digest_core.sv -----
// MD5 digest core: takes one byte word per cycle while the front has room.
// Each 64-byte block passes through the back in order: load, 64 rounds, fold.
// After the last byte, full stays high while the pad and length bytes are placed.
// The first digest word appears once the final block has passed the queue and the
// back (load, rounds, fold); the other three follow on pop.
// Synchronous active-high reset restores the initial chaining words and length.
module md5_message_digest_core #(
   parameter int unsigned QUEUE_DEPTH = md5_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last_byte,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic in_ready, fq_valid, fq_ready, qb_valid, qb_ready, out_valid;
   md5_pkg::block_type fq_data, qb_data;

   assign full  = !in_ready;
   assign empty = !out_valid;

   md5_front u_front (
      .clock, .reset,
      .in_valid(push), .in_ready,
      .data_byte(req_data_byte), .byte_valid(req_byte_valid), .last_byte(req_last_byte),
      .blk_valid(fq_valid), .blk_ready(fq_ready), .blk_out(fq_data)
   );

   md5_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
      .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
   );

   md5_back u_back (
      .clock, .reset,
      .blk_valid(qb_valid), .blk_ready(qb_ready), .blk_in(qb_data),
      .out_valid, .out_ready(pop),
      .out_word(rsp_digest_word), .out_index(rsp_word_index), .out_last(rsp_last_word)
   );

   a_last_is_three: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_last_word == (rsp_word_index == 2'd3)))
      else $error("last word flag does not match index");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last_word) |=> (!empty && rsp_word_index == $past(rsp_word_index) + 2'd1))
      else $error("digest words not in order");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_digest_word)))
      else $error("digest word changed while waiting");

endmodule
